[src/pfa_pkg.sv]
// shared constants, types and control structs of the partition fit allocator
package pfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    localparam int ENTRY_W    = 4;
    localparam int FIELD_W    = 16;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        MODE_FIXED = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_BEST  = 2'd2,
        MODE_WORST = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit_req;
        logic commit_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

[src/pfa_ctrl.sv]
// sequencing state machine of the partition fit allocator
module pfa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_op,
    output logic             in_stall,
    input  pfa_pkg::status_t status,
    output pfa_pkg::cmd_t    cmd
);

    pfa_pkg::state_t state_reg;
    pfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_op == pfa_pkg::OP_LOAD)
                    begin
                        state_next = pfa_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = pfa_pkg::ST_SCAN;
                    end
                end
            end
            pfa_pkg::ST_LOAD:
            begin
                cmd.commit_load = 1'b1;
                state_next      = pfa_pkg::ST_FINISH;
            end
            pfa_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = pfa_pkg::ST_UPDATE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            pfa_pkg::ST_UPDATE:
            begin
                cmd.commit_req = 1'b1;
                state_next     = pfa_pkg::ST_FINISH;
            end
            pfa_pkg::ST_FINISH:
            begin
                // wait for room in the output register
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/pfa_datapath.sv]
// size table, taken flags, scan registers and result registers
module pfa_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pfa_pkg::cmd_t                     cmd,
    output pfa_pkg::status_t                  status,
    input  logic                              cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              op,
    input  logic [pfa_pkg::ENTRY_W-1:0]       entry_index,
    input  logic [pfa_pkg::FIELD_W-1:0]       size_value,
    input  logic                              last_request,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              granted,
    output logic [pfa_pkg::ENTRY_W-1:0]       chosen_block,
    output logic [pfa_pkg::FIELD_W-1:0]       leftover,
    output logic                              batch_done
);

    logic [pfa_pkg::SIZE_BITS-1:0] free_size [pfa_pkg::NUM_BLOCKS];
    logic [pfa_pkg::NUM_BLOCKS-1:0] taken_reg;

    pfa_pkg::mode_t                 mode_reg;
    logic [pfa_pkg::CFG_DATA_W-1:0] blocks_reg;

    logic                           op_reg;
    logic [pfa_pkg::ENTRY_W-1:0]    idx_reg;
    logic [pfa_pkg::SIZE_BITS-1:0]  size_reg;
    logic                           last_reg;

    logic [pfa_pkg::CNT_W-1:0]      j_reg;
    logic [pfa_pkg::CNT_W-1:0]      n_reg;
    logic [pfa_pkg::CNT_W-1:0]      n_next;
    logic                           found_reg;
    logic                           found_next;
    logic [pfa_pkg::IDX_W-1:0]      pick_reg;
    logic [pfa_pkg::IDX_W-1:0]      pick_next;
    logic [pfa_pkg::SIZE_BITS-1:0]  best_reg;
    logic [pfa_pkg::SIZE_BITS-1:0]  best_next;

    logic                           res_granted_reg;
    logic [pfa_pkg::ENTRY_W-1:0]    res_block_reg;
    logic [pfa_pkg::FIELD_W-1:0]    res_left_reg;
    logic                           res_batch_reg;

    logic                           out_valid_reg;
    logic                           granted_reg;
    logic [pfa_pkg::ENTRY_W-1:0]    chosen_block_reg;
    logic [pfa_pkg::FIELD_W-1:0]    leftover_reg;
    logic                           batch_done_reg;

    logic [pfa_pkg::IDX_W-1:0]      scan_addr;
    logic [pfa_pkg::IDX_W-1:0]      rd_addr;
    logic [pfa_pkg::SIZE_BITS-1:0]  scan_size_reg;
    logic [pfa_pkg::SIZE_BITS-1:0]  scan_size;
    logic                           fits;
    logic                           take;
    logic [pfa_pkg::SIZE_BITS-1:0]  left;
    logic                           load_in_range;
    logic [pfa_pkg::IDX_W-1:0]      load_addr;

    assign scan_addr     = j_reg[pfa_pkg::IDX_W-1:0];
    // fetch one entry ahead so the registered word matches the entry under test
    assign rd_addr       = cmd.scan_step ? pfa_pkg::IDX_W'(j_reg + 1'b1) : '0;
    assign scan_size     = scan_size_reg;
    assign fits          = (scan_size >= size_reg);
    assign left          = best_reg - size_reg;
    assign load_in_range = ({28'd0, idx_reg} < 32'(pfa_pkg::NUM_BLOCKS));
    assign load_addr     = pfa_pkg::IDX_W'(idx_reg);

    assign n_next = (32'(blocks_reg) > 32'(pfa_pkg::NUM_BLOCKS))
                    ? pfa_pkg::CNT_W'(pfa_pkg::NUM_BLOCKS)
                    : pfa_pkg::CNT_W'(blocks_reg);

    assign status.scan_done = (j_reg == n_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    // candidate selection for the current table entry
    always_comb
    begin
        take = 1'b0;
        case (mode_reg)
            pfa_pkg::MODE_FIXED: take = fits && !found_reg && !taken_reg[scan_addr];
            pfa_pkg::MODE_FIRST: take = fits && !found_reg;
            pfa_pkg::MODE_BEST:  take = fits && (!found_reg || scan_size < best_reg);
            pfa_pkg::MODE_WORST: take = fits && (!found_reg || scan_size > best_reg);
            default:             take = 1'b0;
        endcase
        found_next = found_reg | take;
        pick_next  = take ? scan_addr : pick_reg;
        best_next  = take ? scan_size : best_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pfa_pkg::MODE_FIRST;
            blocks_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfa_pkg::CFG_FIT_MODE:    mode_reg   <= pfa_pkg::mode_t'(cfg_data[1:0]);
                pfa_pkg::CFG_BLOCK_COUNT: blocks_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // size table, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.commit_load && load_in_range)
        begin
            free_size[load_addr] <= size_reg;
        end
        else if (cmd.commit_req && found_reg && mode_reg != pfa_pkg::MODE_FIXED)
        begin
            free_size[pick_reg] <= left;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_size_reg <= free_size[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else if (cmd.commit_load && load_in_range)
        begin
            taken_reg[load_addr] <= 1'b0;
        end
        else if (cmd.commit_req && found_reg && mode_reg == pfa_pkg::MODE_FIXED)
        begin
            taken_reg[pick_reg] <= 1'b1;
        end
    end

    // captured transaction and scan state
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            idx_reg   <= entry_index;
            size_reg  <= pfa_pkg::SIZE_BITS'(size_value);
            last_reg  <= last_request;
            n_reg     <= n_next;
            j_reg     <= '0;
            found_reg <= 1'b0;
            pick_reg  <= '0;
            best_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            j_reg     <= j_reg + 1'b1;
            found_reg <= found_next;
            pick_reg  <= pick_next;
            best_reg  <= best_next;
        end
    end

    // staged result
    always_ff @(posedge clk)
    begin
        if (cmd.commit_load)
        begin
            res_granted_reg <= 1'b0;
            res_block_reg   <= '0;
            res_left_reg    <= '0;
            res_batch_reg   <= 1'b0;
        end
        else if (cmd.commit_req)
        begin
            res_granted_reg <= found_reg;
            res_block_reg   <= found_reg ? pfa_pkg::ENTRY_W'(pick_reg) : '0;
            res_left_reg    <= found_reg ? pfa_pkg::FIELD_W'(left) : '0;
            res_batch_reg   <= last_reg && (op_reg == pfa_pkg::OP_REQUEST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            granted_reg      <= res_granted_reg;
            chosen_block_reg <= res_block_reg;
            leftover_reg     <= res_left_reg;
            batch_done_reg   <= res_batch_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign chosen_block = chosen_block_reg;
    assign leftover     = leftover_reg;
    assign batch_done   = batch_done_reg;

endmodule

[src/partition_fit_allocator.sv]
// top level of the partition fit allocator
// A load transaction (op 0) writes one entry of the block size table and clears its used
// mark; a request transaction (op 1) searches the first blocks_in_use entries under fit_mode
// (fixed, first, best or worst fit) and answers with granted, chosen_block, leftover and
// batch_done. One transaction is handled at a time: a load goes through the load and finish
// states until its result is loaded into the output register, a request through the scan,
// update and finish states, scanning one table entry per cycle over blocks_in_use entries
// capped at the table depth. The next transaction is accepted in the cycle after the result
// is loaded, never before, and a stalled result holds the block in the finish state until
// the output register has room. The output register lets a new transaction be accepted while
// the last result is still stalled. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle, which it does not enforce.
module partition_fit_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [pfa_pkg::ENTRY_W-1:0]    entry_index,
    input  logic [pfa_pkg::FIELD_W-1:0]    size_value,
    input  logic                           last_request,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           granted,
    output logic [pfa_pkg::ENTRY_W-1:0]    chosen_block,
    output logic [pfa_pkg::FIELD_W-1:0]    leftover,
    output logic                           batch_done
);

    pfa_pkg::cmd_t    cmd;
    pfa_pkg::status_t status;

    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pfa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .entry_index  (entry_index),
        .size_value   (size_value),
        .last_request (last_request),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted      (granted),
        .chosen_block (chosen_block),
        .leftover     (leftover),
        .batch_done   (batch_done)
    );

endmodule
